/* rtl/scalar_kalman_filter_macros.svh */
// Assertion shorthands shared by the filter modules.
// Each expects clk and rst_n in scope.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication.
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps

package skf_pkg;

  // Number formats
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIST_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int GAIN_W    = FRAC_BITS;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int SAMPLE_W  = DIST_W + FRAC_BITS;
  localparam int MAG_W     = (SAMPLE_W > DATA_W) ? SAMPLE_W : DATA_W;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DEN_W     = ((DATA_W > CFG_W + FRAC_BITS) ? DATA_W : CFG_W + FRAC_BITS) + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int PROD_W    = QUO_W + MAG_W;
  localparam int EST_SUM_W = MAG_W + 1;
  localparam int COV_SUM_W = PROD_W - FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam logic [QUO_W-1:0] GAIN_ONE = QUO_W'(1) << FRAC_BITS;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 1'd1;
  localparam logic [CFG_W-1:0]     MEAS_NOISE_RST    = 16'd40;
  localparam logic [CFG_W-1:0]     PROCESS_NOISE_RST = 16'd10;

  // Datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV     = 3'd2;
  localparam logic [OP_W-1:0] OP_GAIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL_EST = 3'd4;
  localparam logic [OP_W-1:0] OP_EST     = 3'd5;
  localparam logic [OP_W-1:0] OP_MUL_COV = 3'd6;
  localparam logic [OP_W-1:0] OP_COV     = 3'd7;

  // Jump conditions: jump to target when true, else step on
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_NEXT     = 2'd0;
  localparam logic [COND_W-1:0] COND_WAIT_IN  = 2'd1;
  localparam logic [COND_W-1:0] COND_LOOP     = 2'd2;
  localparam logic [COND_W-1:0] COND_WAIT_OUT = 2'd3;

  // Program addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
  localparam logic [PC_W-1:0] PC_LOAD    = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV     = 3'd2;
  localparam logic [PC_W-1:0] PC_GAIN    = 3'd3;
  localparam logic [PC_W-1:0] PC_MUL_EST = 3'd4;
  localparam logic [PC_W-1:0] PC_EST     = 3'd5;
  localparam logic [PC_W-1:0] PC_MUL_COV = 3'd6;
  localparam logic [PC_W-1:0] PC_COV     = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } skf_ucode_t;

  typedef struct packed {
    logic            fire;
    logic [OP_W-1:0] op;
  } skf_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } skf_stat_t;

  function automatic skf_ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    skf_ucode_t w;
    w = '{op: OP_ACCEPT, cond: COND_WAIT_IN, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:    w = '{op: OP_ACCEPT,  cond: COND_WAIT_IN,  target: PC_IDLE};
      PC_LOAD:    w = '{op: OP_LOAD,    cond: COND_NEXT,     target: PC_IDLE};
      PC_DIV:     w = '{op: OP_DIV,     cond: COND_LOOP,     target: PC_DIV};
      PC_GAIN:    w = '{op: OP_GAIN,    cond: COND_NEXT,     target: PC_IDLE};
      PC_MUL_EST: w = '{op: OP_MUL_EST, cond: COND_NEXT,     target: PC_IDLE};
      PC_EST:     w = '{op: OP_EST,     cond: COND_NEXT,     target: PC_IDLE};
      PC_MUL_COV: w = '{op: OP_MUL_COV, cond: COND_NEXT,     target: PC_IDLE};
      PC_COV:     w = '{op: OP_COV,     cond: COND_WAIT_OUT, target: PC_COV};
      default:    w = '{op: OP_ACCEPT,  cond: COND_WAIT_IN,  target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/skf_in_if.sv */
`timescale 1ns / 1ps

interface skf_in_if;
  logic                        valid;
  logic                        ready;
  logic [skf_pkg::DIST_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

/* rtl/skf_out_if.sv */
`timescale 1ns / 1ps

interface skf_out_if;
  logic                        valid;
  logic                        ready;
  logic [skf_pkg::DATA_W-1:0]  estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

/* rtl/skf_sequencer.sv */
`timescale 1ns / 1ps
`include "scalar_kalman_filter_macros.svh"

module skf_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skf_pkg::skf_stat_t    stat,
  output logic                  in_ready,
  output skf_pkg::skf_ctrl_t    ctrl
);

  logic [skf_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [skf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  skf_pkg::skf_ucode_t       word;
  logic                      jump;
  logic                      stall;

  assign word = skf_pkg::ucode_rom(pc_r);

  always_comb begin
    unique case (word.cond)
      skf_pkg::COND_NEXT:     jump = 1'b0;
      skf_pkg::COND_WAIT_IN:  jump = !stat.in_valid;
      skf_pkg::COND_LOOP:     jump = (cnt_r != '0);
      skf_pkg::COND_WAIT_OUT: jump = stat.out_busy;
      default:                jump = 1'b0;
    endcase
  end

  // Waiting steps hold the datapath; the loop step always executes.
  assign stall     = jump && (word.cond != skf_pkg::COND_LOOP);
  assign ctrl.fire = !stall;
  assign ctrl.op   = word.op;
  assign in_ready  = (pc_r == skf_pkg::PC_IDLE);

  always_comb begin
    pc_nxt  = jump ? word.target : pc_r + 1'b1;
    cnt_nxt = cnt_r;
    if (word.op == skf_pkg::OP_LOAD) begin
      cnt_nxt = skf_pkg::CNT_W'(skf_pkg::QUO_W - 1);
    end else if (word.op == skf_pkg::OP_DIV && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= skf_pkg::PC_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `SKF_ASSERT_NXT(a_accept_to_load, stat.in_valid && in_ready, pc_r == skf_pkg::PC_LOAD, "accepted sample did not start a load")
  `SKF_ASSERT_IMP(a_count_in_div, cnt_r != '0, pc_r == skf_pkg::PC_DIV, "divide count live outside the divide loop")

endmodule

/* rtl/skf_datapath.sv */
`timescale 1ns / 1ps
`include "scalar_kalman_filter_macros.svh"

module skf_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  skf_pkg::skf_ctrl_t            ctrl,
  input  logic [skf_pkg::DIST_W-1:0]    in_distance,
  input  logic [skf_pkg::CFG_W-1:0]     meas_noise,
  input  logic [skf_pkg::CFG_W-1:0]     process_noise,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [skf_pkg::DATA_W-1:0]    out_estimate,
  output logic                          out_busy
);

  // Filter state
  logic [skf_pkg::DATA_W-1:0]  est_r, est_nxt;
  logic [skf_pkg::DATA_W-1:0]  cov_r, cov_nxt;
  // Working registers
  logic [skf_pkg::DIST_W-1:0]  sample_r, sample_nxt;
  logic [skf_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [skf_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [skf_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [skf_pkg::GAIN_W-1:0]  gain_r, gain_nxt;
  logic                        up_r, up_nxt;
  logic [skf_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [skf_pkg::DATA_W-1:0]  out_est_r, out_est_nxt;

  logic [skf_pkg::NUM_W-1:0]     num;
  logic [skf_pkg::REM_W-1:0]     shifted;
  logic                          ge;
  logic [skf_pkg::MAG_W-1:0]     sample_al;
  logic [skf_pkg::MAG_W-1:0]     est_ext;
  logic                          up;
  logic [skf_pkg::MAG_W-1:0]     mag;
  logic [skf_pkg::QUO_W-1:0]     mul_a;
  logic [skf_pkg::MAG_W-1:0]     mul_b;
  logic [skf_pkg::PROD_W-1:0]    mul_out;
  logic [skf_pkg::PROD_W-1:0]    delta;
  logic [skf_pkg::EST_SUM_W-1:0] est_sum;
  logic [skf_pkg::COV_SUM_W-1:0] pn_aligned;
  logic [skf_pkg::COV_SUM_W-1:0] cov_sum;

  assign num       = skf_pkg::NUM_W'(cov_r) << skf_pkg::FRAC_BITS;
  assign shifted   = {rem_r[skf_pkg::REM_W-2:0], quo_r[skf_pkg::QUO_W-1]};
  assign ge        = (shifted >= skf_pkg::REM_W'(den_r));
  assign sample_al = skf_pkg::MAG_W'(sample_r) << skf_pkg::FRAC_BITS;
  assign est_ext   = skf_pkg::MAG_W'(est_r);
  assign up        = (sample_al >= est_ext);
  assign mag       = up ? (sample_al - est_ext) : (est_ext - sample_al);
  assign delta     = prod_r >> skf_pkg::FRAC_BITS;
  assign est_sum   = skf_pkg::EST_SUM_W'(est_r) + skf_pkg::EST_SUM_W'(delta);
  assign pn_aligned = skf_pkg::COV_SUM_W'(process_noise) << skf_pkg::FRAC_BITS;
  assign cov_sum   = skf_pkg::COV_SUM_W'(delta) + pn_aligned;

  // One shared multiplier, operands picked by the current step
  always_comb begin
    case (ctrl.op)
      skf_pkg::OP_MUL_EST: begin
        mul_a = skf_pkg::QUO_W'(gain_r);
        mul_b = mag;
      end
      skf_pkg::OP_MUL_COV: begin
        mul_a = skf_pkg::GAIN_ONE - skf_pkg::QUO_W'(gain_r);
        mul_b = skf_pkg::MAG_W'(cov_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_comb begin
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    sample_nxt    = sample_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    gain_nxt      = gain_r;
    up_nxt        = up_r;
    prod_nxt      = prod_r;
    out_est_nxt   = out_est_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctrl.fire) begin
      unique case (ctrl.op)
        skf_pkg::OP_ACCEPT: begin
          sample_nxt = in_distance;
        end
        skf_pkg::OP_LOAD: begin
          den_nxt = skf_pkg::DEN_W'(cov_r)
                  + (skf_pkg::DEN_W'(meas_noise) << skf_pkg::FRAC_BITS);
          rem_nxt = skf_pkg::REM_W'(num >> skf_pkg::QUO_W);
          quo_nxt = num[skf_pkg::QUO_W-1:0];
        end
        skf_pkg::OP_DIV: begin
          // One restoring step: quotient bits shift in where dividend bits leave
          rem_nxt = ge ? (shifted - skf_pkg::REM_W'(den_r)) : shifted;
          quo_nxt = {quo_r[skf_pkg::QUO_W-2:0], ge};
        end
        skf_pkg::OP_GAIN: begin
          if (den_r == '0) begin
            gain_nxt = '0;
          end else if (quo_r[skf_pkg::QUO_W-1]) begin
            gain_nxt = '1;
          end else begin
            gain_nxt = quo_r[skf_pkg::GAIN_W-1:0];
          end
        end
        skf_pkg::OP_MUL_EST: begin
          prod_nxt = mul_out;
          up_nxt   = up;
        end
        skf_pkg::OP_EST: begin
          if (up_r) begin
            est_nxt = (est_sum[skf_pkg::EST_SUM_W-1:skf_pkg::DATA_W] != '0)
                    ? '1 : est_sum[skf_pkg::DATA_W-1:0];
          end else begin
            est_nxt = est_r - delta[skf_pkg::DATA_W-1:0];
          end
        end
        skf_pkg::OP_MUL_COV: begin
          prod_nxt = mul_out;
        end
        skf_pkg::OP_COV: begin
          cov_nxt = (cov_sum[skf_pkg::COV_SUM_W-1:skf_pkg::DATA_W] != '0)
                  ? '1 : cov_sum[skf_pkg::DATA_W-1:0];
          out_est_nxt   = est_r;
          out_valid_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r       <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    gain_r    <= gain_nxt;
    up_r      <= up_nxt;
    prod_r    <= prod_nxt;
    out_est_r <= out_est_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_busy     = out_valid_r && !out_ready;

  `SKF_ASSERT_IMP(a_rem_below_den, ctrl.op == skf_pkg::OP_DIV && den_r != '0, rem_r < skf_pkg::REM_W'(den_r), "partial remainder reached the divisor")
  `SKF_ASSERT_NXT(a_cov_floor, ctrl.fire && ctrl.op == skf_pkg::OP_COV, cov_r >= $past(pn_aligned), "covariance fell below process noise")
  `SKF_ASSERT_IMP(a_out_from_cov, $rose(out_valid_r), $past(ctrl.fire && ctrl.op == skf_pkg::OP_COV), "result raised outside the covariance step")

endmodule

/* rtl/scalar_kalman_filter.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload                        Transfer
// in_ch     in   distance   16 b unsigned int   valid & ready
// out_ch    out  estimate   32 b unsigned Q16.16 valid & ready
// cfg_*     in   index 1 b, data 16 b           cfg_we high
//
// Each sample runs 24 program steps: accept, load, 17 restoring divide
// iterations, gain, two multiplies and two updates; the divider loop sets this.
// The result is registered by the last step, and a new sample is taken only
// once the program is back at accept, later while a result waits for out_ch.ready.
// Reset (rst_n low, synchronous) gives meas_noise 40, process_noise 10 and a
// zero estimate and covariance; a waiting result holds the next sample at its last step.

module scalar_kalman_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  skf_in_if.sink                          in_ch,
  skf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skf_pkg::CFG_W-1:0]       cfg_data
);

  // Configuration registers; user must write only while the filter is idle; unchecked
  logic [skf_pkg::CFG_W-1:0] meas_noise_r, meas_noise_nxt;
  logic [skf_pkg::CFG_W-1:0] process_noise_r, process_noise_nxt;

  skf_pkg::skf_ctrl_t ctrl;
  skf_pkg::skf_stat_t stat;
  logic               in_ready;
  logic               out_busy;

  always_comb begin
    meas_noise_nxt    = meas_noise_r;
    process_noise_nxt = process_noise_r;
    if (cfg_we) begin
      case (cfg_index)
        skf_pkg::CFG_MEAS_NOISE:    meas_noise_nxt    = cfg_data;
        skf_pkg::CFG_PROCESS_NOISE: process_noise_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_noise_r    <= skf_pkg::MEAS_NOISE_RST;
      process_noise_r <= skf_pkg::PROCESS_NOISE_RST;
    end else begin
      meas_noise_r    <= meas_noise_nxt;
      process_noise_r <= process_noise_nxt;
    end
  end

  // Status seen by the program's jump conditions
  assign stat.in_valid = in_ch.valid;
  assign stat.out_busy = out_busy;

  // Step through the microprogram
  skf_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = in_ready;

  // Divider, shared multiplier, filter state and output register
  skf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_distance   (in_ch.distance),
    .meas_noise    (meas_noise_r),
    .process_noise (process_noise_r),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_estimate  (out_ch.estimate),
    .out_busy      (out_busy)
  );

endmodule

/* tb/tb_scalar_kalman_filter.sv */
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;

  // Fixed-point helpers for the filter predictor
  localparam logic [63:0] UNITY     = 64'd1 << skf_pkg::FRAC_BITS;
  localparam logic [63:0] GAIN_CEIL = (64'd1 << skf_pkg::FRAC_BITS) - 64'd1;
  localparam logic [63:0] WORD_MAX  = 64'hFFFF_FFFF;

  // Run-time guards: each sample needs its program steps plus stalls, so this is ample
  localparam int LIMIT_CYCLES   = 600000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int ITEMS_PER_STEP = 125;

  // Tracks the filter state, predicts each estimate and checks what the block returns
  class kalman_tracker;
    logic [skf_pkg::CFG_W-1:0]  noise_r;
    logic [skf_pkg::CFG_W-1:0]  noise_q;
    logic [skf_pkg::DATA_W-1:0] cov_p;
    logic [skf_pkg::DATA_W-1:0] est_x;
    logic [skf_pkg::DATA_W-1:0] expected_estimates[$];
    int                         mismatches;

    function new();
      noise_r = skf_pkg::MEAS_NOISE_RST;
      noise_q = skf_pkg::PROCESS_NOISE_RST;
      cov_p   = '0;
      est_x   = '0;
      mismatches = 0;
    endfunction

    // One filter step: gain, estimate update, covariance update
    function logic [skf_pkg::DATA_W-1:0] advance_filter(logic [skf_pkg::DIST_W-1:0] sample_val);
      logic [63:0] aligned, cov, est, denom, gain, delta, ncov;
      aligned = 64'(sample_val) << skf_pkg::FRAC_BITS;
      cov     = 64'(cov_p);
      est     = 64'(est_x);
      denom   = cov + (64'(noise_r) << skf_pkg::FRAC_BITS);
      gain    = '0;
      if (denom != 0) begin
        gain = (cov << skf_pkg::FRAC_BITS) / denom;
      end
      // Zero noise lets the quotient reach one; clip to the largest Q0 gain
      if (gain > GAIN_CEIL) begin
        gain = GAIN_CEIL;
      end
      if (aligned >= est) begin
        delta = (gain * (aligned - est)) >> skf_pkg::FRAC_BITS;
        est   = est + delta;
        if (est > WORD_MAX) begin
          est = WORD_MAX;
        end
      end else begin
        delta = (gain * (est - aligned)) >> skf_pkg::FRAC_BITS;
        est   = est - delta;
      end
      ncov = (((UNITY - gain) * cov) >> skf_pkg::FRAC_BITS)
           + (64'(noise_q) << skf_pkg::FRAC_BITS);
      if (ncov > WORD_MAX) begin
        ncov = WORD_MAX;
      end
      cov_p = ncov[skf_pkg::DATA_W-1:0];
      est_x = est[skf_pkg::DATA_W-1:0];
      return est_x;
    endfunction

    function void note_sample(logic [skf_pkg::DIST_W-1:0] sample_val);
      expected_estimates.push_back(advance_filter(sample_val));
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_estimate(logic [skf_pkg::DATA_W-1:0] got);
      logic [skf_pkg::DATA_W-1:0] want;
      if (expected_estimates.size() == 0) begin
        report($sformatf("estimate %h with no sample outstanding", got));
      end else begin
        want = expected_estimates.pop_front();
        if (got !== want) begin
          report($sformatf("estimate %h, predicted %h", got, want));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [skf_pkg::CFG_W-1:0]     cfg_data;
  logic steady;   // high: neither side idles
  int   cycles = 0;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  kalman_tracker board;

  scalar_kalman_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_scalar_kalman_filter: FAIL");
      $finish;
    end
  end

  // Result side: check every transfer against the oldest prediction, then
  // choose the next ready level (low with odds of 12 in 100 unless steady)
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_estimate(out_ch.estimate);
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 12);
  end

  // Offer one sample; hold valid until the transfer. Valid stays high on
  // return so that a back-to-back sample drops it only in a random idle gap.
  task send_distance(input logic [skf_pkg::DIST_W-1:0] sample_val);
    while (!steady && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.distance <= sample_val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_sample(sample_val);
  endtask

  // Stop offering and hold until every predicted estimate has arrived
  task drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write both noise registers while the block is idle
  task load_noise(input logic [skf_pkg::CFG_W-1:0] r, input logic [skf_pkg::CFG_W-1:0] q);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= skf_pkg::CFG_MEAS_NOISE;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= skf_pkg::CFG_PROCESS_NOISE;
    cfg_data  <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.noise_r = r;
    board.noise_q = q;
  endtask

  // Mostly a noisy track around a held distance, with jumps,
  // fully random samples and the two extremes mixed in
  task run_track(input int n);
    int target, spread, pick, d;
    target = $urandom_range(65535);
    spread = $urandom_range(2000);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        target = $urandom_range(65535);
        spread = $urandom_range(2000);
      end
      if (pick < 10) begin
        d = (pick & 1) ? 65535 : 0;
      end else if (pick < 30) begin
        d = $urandom_range(65535);
      end else begin
        d = target + $urandom_range(2 * spread) - spread;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
      end
      send_distance(d[skf_pkg::DIST_W-1:0]);
    end
  endtask

  initial begin
    board = new();
    steady          <= 1'b0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= skf_pkg::CFG_MEAS_NOISE;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.distance  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero covariance gives zero gain on the first sample,
    // then the extremes and alternating bit patterns
    send_distance(16'd0);
    send_distance(16'hFFFF);
    send_distance(16'd0);
    send_distance(16'hAAAA);
    send_distance(16'h5555);
    send_distance(16'hFFFF);

    // Zero noise: gain clips just below one, covariance collapses to zero,
    // and then the zero denominator yields zero gain
    load_noise(16'd0, 16'd0);
    send_distance(16'hFFFF);
    send_distance(16'd1234);
    send_distance(16'd0);
    send_distance(16'h8000);
    send_distance(16'hFFFF);

    // Largest noise on both: covariance runs into saturation
    load_noise(16'hFFFF, 16'hFFFF);
    send_distance(16'hFFFF);
    send_distance(16'd0);
    send_distance(16'hFFFF);
    send_distance(16'd0);
    send_distance(16'h7FFF);
    send_distance(16'hFFFF);

    // Smallest legal measurement noise, no process noise
    load_noise(16'd1, 16'd0);
    send_distance(16'd0);
    send_distance(16'hFFFF);
    send_distance(16'd42);

    // Random tracks under a sweep of noise settings; each change of
    // setting holds the sender until all results are back
    load_noise(skf_pkg::MEAS_NOISE_RST, skf_pkg::PROCESS_NOISE_RST);
    run_track(ITEMS_PER_STEP);
    load_noise(16'd1, 16'hFFFF);
    run_track(ITEMS_PER_STEP);
    // Long stretch with neither side idling
    steady <= 1'b1;
    load_noise(skf_pkg::CFG_W'($urandom_range(65535, 1)),
               skf_pkg::CFG_W'($urandom_range(65535)));
    run_track(ITEMS_PER_STEP);
    drain_results();
    steady <= 1'b0;
    load_noise(16'hFFFF, 16'd0);
    run_track(ITEMS_PER_STEP);
    load_noise(16'd0, skf_pkg::CFG_W'($urandom_range(65535)));
    run_track(ITEMS_PER_STEP);
    load_noise(skf_pkg::CFG_W'($urandom_range(65535, 1)),
               skf_pkg::CFG_W'($urandom_range(255)));
    run_track(ITEMS_PER_STEP);

    // Wait for the last results, then give stray transfers time to appear
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_scalar_kalman_filter: PASS");
    end else begin
      $display("tb_scalar_kalman_filter: FAIL");
    end
    $finish;
  end

endmodule
